// ----- src/rtprb_pkg.sv -----
// ----------------------------------------------------------------------------
// rtprb_pkg
// Shared widths, codes and types of the RTP reorder buffer.
// ----------------------------------------------------------------------------
package rtprb_pkg;

  localparam int SEQ_W       = 16;
  localparam int LEN_W       = 12;
  localparam int WIN_W       = 15;
  localparam int BUDGET_W    = 16;
  localparam int STATUS_W    = 3;
  localparam int ACT_W       = 2;
  localparam int RES_CNT_W   = 6;
  localparam int MAX_RESULTS = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 15'd1000;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT       = 2'd0,
    ACT_DRAIN_KEEP   = 2'd1,
    ACT_DRAIN_REMOVE = 2'd2,
    ACT_RESERVED     = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_INVALID  = 3'd1,
    STAT_NO_SLOT  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_DRAINED  = 3'd4,
    STAT_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_WA,
    S_INS_WB,
    S_DR_EVAL,
    S_DR_FLUSH,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    INS_FIRST,
    INS_HEAD,
    INS_MID,
    INS_TAIL
  } ins_mode_t;

  typedef struct packed {
    logic node;
    logic next;
    logic prev;
  } mem_we_t;

endpackage

// ----- src/rtprb_mem.sv -----
// ----------------------------------------------------------------------------
// rtprb_mem
// Descriptor store: sequence, length and link arrays, one registered read.
// ----------------------------------------------------------------------------
module rtprb_mem #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  rtprb_pkg::mem_we_t            we,
  input  logic [$clog2(DEPTH)-1:0]      node_addr,
  input  logic [rtprb_pkg::SEQ_W-1:0]   node_seq,
  input  logic [rtprb_pkg::LEN_W-1:0]   node_len,
  input  logic [$clog2(DEPTH)-1:0]      next_addr,
  input  logic [$clog2(DEPTH)-1:0]      next_data,
  input  logic [$clog2(DEPTH)-1:0]      prev_addr,
  input  logic [$clog2(DEPTH)-1:0]      prev_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [rtprb_pkg::SEQ_W-1:0]   rd_seq,
  output logic [rtprb_pkg::LEN_W-1:0]   rd_len,
  output logic [$clog2(DEPTH)-1:0]      rd_next,
  output logic [$clog2(DEPTH)-1:0]      rd_prev
);

  localparam int PW = $clog2(DEPTH);

  logic [rtprb_pkg::SEQ_W-1:0] seq_mem  [DEPTH];
  logic [rtprb_pkg::LEN_W-1:0] len_mem  [DEPTH];
  logic [PW-1:0]               next_mem [DEPTH];
  logic [PW-1:0]               prev_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.node) begin
      seq_mem[node_addr] <= node_seq;
      len_mem[node_addr] <= node_len;
    end
    if (we.next) begin
      next_mem[next_addr] <= next_data;
    end
    if (we.prev) begin
      prev_mem[prev_addr] <= prev_data;
    end
    if (rd_en) begin
      rd_seq  <= seq_mem[rd_addr];
      rd_len  <= len_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
    end
  end

endmodule

// ----- src/rtprb_seq_cmp.sv -----
// ----------------------------------------------------------------------------
// rtprb_seq_cmp
// Wrap-aware seq distance: flags strictly positive a to b, or beyond window.
// ----------------------------------------------------------------------------
module rtprb_seq_cmp #(
  parameter int SEQ_MAX = 65535
) (
  input  logic [rtprb_pkg::SEQ_W-1:0] a,
  input  logic [rtprb_pkg::SEQ_W-1:0] b,
  input  logic [rtprb_pkg::WIN_W-1:0] window,
  output logic                        pos
);

  localparam logic [rtprb_pkg::SEQ_W-1:0] SEQ_MASK = 16'(SEQ_MAX);
  localparam logic [17:0]                 SEQ_MOD  = 18'(SEQ_MAX) + 18'd1;

  logic [rtprb_pkg::SEQ_W-1:0] am, bm, dab, dba, mn, e;
  logic                        near;

  always_comb begin
    am   = a & SEQ_MASK;
    bm   = b & SEQ_MASK;
    dab  = (am - bm) & SEQ_MASK;
    dba  = (bm - am) & SEQ_MASK;
    mn   = (dab < dba) ? dab : dba;
    near = ({1'b0, mn} <= {2'b00, window});
    e    = (am > bm) ? (am - bm) : (bm - am);
    priority if (!near) begin
      pos = 1'b1;
    end else if (am > bm) begin
      pos = (SEQ_MOD < {1'b0, e, 1'b0});
    end else if (am < bm) begin
      pos = ({1'b0, e, 1'b0} < SEQ_MOD);
    end else begin
      pos = 1'b0;
    end
  end

endmodule

// ----- src/rtp_reorder_buffer_core.sv -----
// ----------------------------------------------------------------------------
// rtp_reorder_buffer_core
// Reorder table of RTP packet descriptors kept as a linked list in memory.
// ----------------------------------------------------------------------------
// One item at a time. An insert walks the list from the tail, one entry per
// cycle through the single read port of the descriptor store, then writes the
// links in the states S_INS_WA and S_INS_WB. A drain reads one entry per cycle
// and delivers one result per cycle while out_stall is low. There is no
// clearing pass after reset.
module rtp_reorder_buffer_core #(
  parameter int DEPTH   = 32,
  parameter int SEQ_MAX = 65535
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rtprb_pkg::ACT_W-1:0]      in_action,
  input  logic [rtprb_pkg::SEQ_W-1:0]      in_seq_num,
  input  logic [rtprb_pkg::LEN_W-1:0]      in_payload_len,
  input  logic                             in_packet_valid,
  input  logic [rtprb_pkg::BUDGET_W-1:0]   in_byte_budget,
  input  logic                             in_take_gapped,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rtprb_pkg::STATUS_W-1:0]   out_status,
  output logic [rtprb_pkg::SEQ_W-1:0]      out_out_seq,
  output logic [rtprb_pkg::LEN_W-1:0]      out_out_len,
  output logic [rtprb_pkg::SEQ_W-1:0]      out_first_seq,
  output logic [rtprb_pkg::SEQ_W-1:0]      out_last_seq,
  output logic [rtprb_pkg::BUDGET_W-1:0]   out_total_bytes,
  output logic                             out_last,
  input  logic                             cfg_wr_en,
  input  logic [rtprb_pkg::WIN_W-1:0]      cfg_near_window
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [rtprb_pkg::SEQ_W-1:0] SEQ_MASK = 16'(SEQ_MAX);

  rtprb_pkg::state_t                 state_r, state_nxt;
  rtprb_pkg::ins_mode_t              mode_r;
  rtprb_pkg::action_t                act_in, action_r;
  rtprb_pkg::status_t                status_r, push_code;
  rtprb_pkg::mem_we_t                mem_we;

  logic [PW-1:0]                     head_r, tail_r;
  logic [CW-1:0]                     count_r;
  logic [DEPTH-1:0]                  free_r;
  logic [rtprb_pkg::WIN_W-1:0]       nw_r;

  logic [rtprb_pkg::SEQ_W-1:0]       seq_r, sc_seq_r, first_r, pend_seq_r;
  logic [rtprb_pkg::LEN_W-1:0]       len_r, pend_len_r;
  logic [rtprb_pkg::BUDGET_W-1:0]    budget_r, total_r, pend_tot_r;
  logic                              tg_r, hf_r, hs_r;
  logic [PW-1:0]                     f_r, sc_r, slot_r, cur_r;
  logic [rtprb_pkg::RES_CNT_W-1:0]   n_r, n_inc;

  logic                              out_valid_r, out_last_r;
  logic [rtprb_pkg::STATUS_W-1:0]    out_status_r;
  logic [rtprb_pkg::SEQ_W-1:0]       out_seq_r, out_first_r, out_lseq_r;
  logic [rtprb_pkg::LEN_W-1:0]       out_len_r;
  logic [rtprb_pkg::BUDGET_W-1:0]    out_tot_r;

  logic                              in_take, out_free, full, empty;
  logic [PW-1:0]                     free_slot;
  logic                              slot_found;
  logic                              pos_fn, pos_ns, btw;
  logic                              cont, fits, dr_take, dr_end;
  logic [rtprb_pkg::BUDGET_W-1:0]    room, total_add;
  logic                              push_code_en, push_pend, pend_last;

  logic                              rd_en;
  logic [PW-1:0]                     rd_addr, next_addr, next_data, prev_addr, prev_data;
  logic [rtprb_pkg::SEQ_W-1:0]       rd_seq;
  logic [rtprb_pkg::LEN_W-1:0]       rd_len;
  logic [PW-1:0]                     rd_next, rd_prev;

  rtprb_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .node_addr (slot_r),
    .node_seq  (seq_r),
    .node_len  (len_r),
    .next_addr (next_addr),
    .next_data (next_data),
    .prev_addr (prev_addr),
    .prev_data (prev_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_seq    (rd_seq),
    .rd_len    (rd_len),
    .rd_next   (rd_next),
    .rd_prev   (rd_prev)
  );

  rtprb_seq_cmp #(
    .SEQ_MAX (SEQ_MAX)
  ) u_cmp_fn (
    .a      (rd_seq),
    .b      (seq_r),
    .window (nw_r),
    .pos    (pos_fn)
  );

  rtprb_seq_cmp #(
    .SEQ_MAX (SEQ_MAX)
  ) u_cmp_ns (
    .a      (seq_r),
    .b      (sc_seq_r),
    .window (nw_r),
    .pos    (pos_ns)
  );

  assign act_in   = rtprb_pkg::action_t'(in_action);
  assign in_stall = (state_r != rtprb_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    free_slot  = '0;
    slot_found = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_found && free_r[i]) begin
        free_slot  = PW'(i);
        slot_found = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (hf_r && hs_r) begin
      btw = pos_fn && pos_ns;
    end else if (hf_r) begin
      btw = pos_fn;
    end else if (hs_r) begin
      btw = !pos_ns;
    end else begin
      btw = 1'b1;
    end
  end

  assign cont      = (({1'b0, pend_seq_r} + 17'd1) == {1'b0, rd_seq}) ||
                     ((pend_seq_r == SEQ_MASK) && (rd_seq == '0));
  assign room      = budget_r - total_r;
  assign fits      = ({4'd0, rd_len} < room);
  assign dr_take   = fits && (tg_r || (n_r == '0) || cont);
  assign n_inc     = n_r + 6'd1;
  assign total_add = total_r + {4'd0, rd_len};
  assign dr_end    = (cur_r == tail_r) ||
                     (n_inc == rtprb_pkg::RES_CNT_W'(rtprb_pkg::MAX_RESULTS)) ||
                     (int'(n_inc) == int'(count_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtprb_pkg::S_IDLE: begin
        if (in_take) begin
          unique case (act_in)
            rtprb_pkg::ACT_INSERT: begin
              if (!in_packet_valid || full) begin
                state_nxt = rtprb_pkg::S_RESULT;
              end else if (empty) begin
                state_nxt = rtprb_pkg::S_INS_WA;
              end else begin
                state_nxt = rtprb_pkg::S_INS_WALK;
              end
            end
            rtprb_pkg::ACT_DRAIN_KEEP, rtprb_pkg::ACT_DRAIN_REMOVE: begin
              state_nxt = empty ? rtprb_pkg::S_RESULT : rtprb_pkg::S_DR_EVAL;
            end
            rtprb_pkg::ACT_RESERVED: begin
              state_nxt = rtprb_pkg::S_RESULT;
            end
          endcase
        end
      end
      rtprb_pkg::S_INS_WALK: begin
        if (btw) begin
          state_nxt = (!hf_r && !hs_r) ? rtprb_pkg::S_RESULT : rtprb_pkg::S_INS_WA;
        end
      end
      rtprb_pkg::S_INS_WA: begin
        state_nxt = rtprb_pkg::S_INS_WB;
      end
      rtprb_pkg::S_INS_WB, rtprb_pkg::S_DR_FLUSH, rtprb_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = rtprb_pkg::S_IDLE;
        end
      end
      rtprb_pkg::S_DR_EVAL: begin
        if (out_free) begin
          if (!dr_take) begin
            state_nxt = rtprb_pkg::S_IDLE;
          end else if (dr_end) begin
            state_nxt = rtprb_pkg::S_DR_FLUSH;
          end
        end
      end
      default: begin
        state_nxt = rtprb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = head_r;
    mem_we       = '0;
    next_addr    = f_r;
    next_data    = slot_r;
    prev_addr    = (mode_r == rtprb_pkg::INS_HEAD) ? head_r : sc_r;
    prev_data    = slot_r;
    push_code_en = 1'b0;
    push_code    = status_r;
    push_pend    = 1'b0;
    pend_last    = 1'b0;
    unique case (state_r)
      rtprb_pkg::S_IDLE: begin
        if (in_take) begin
          rd_en   = 1'b1;
          rd_addr = (act_in == rtprb_pkg::ACT_INSERT) ? tail_r : head_r;
        end
      end
      rtprb_pkg::S_INS_WALK: begin
        if (!btw && hf_r && (f_r != head_r)) begin
          rd_en   = 1'b1;
          rd_addr = rd_prev;
        end
      end
      rtprb_pkg::S_INS_WA: begin
        mem_we.node = 1'b1;
        mem_we.next = 1'b1;
        mem_we.prev = 1'b1;
        next_addr   = slot_r;
        next_data   = (mode_r == rtprb_pkg::INS_MID) ? sc_r : head_r;
        prev_addr   = slot_r;
        prev_data   = f_r;
      end
      rtprb_pkg::S_INS_WB: begin
        if (out_free) begin
          push_code_en = 1'b1;
          push_code    = rtprb_pkg::STAT_INSERTED;
          mem_we.next  = (mode_r == rtprb_pkg::INS_MID) || (mode_r == rtprb_pkg::INS_TAIL);
          mem_we.prev  = (mode_r == rtprb_pkg::INS_MID) || (mode_r == rtprb_pkg::INS_HEAD);
        end
      end
      rtprb_pkg::S_DR_EVAL: begin
        if (out_free) begin
          if (dr_take) begin
            push_pend = (n_r != '0);
            if (!dr_end) begin
              rd_en   = 1'b1;
              rd_addr = rd_next;
            end
          end else begin
            push_pend = (n_r != '0);
            pend_last = 1'b1;
          end
        end
      end
      rtprb_pkg::S_DR_FLUSH: begin
        push_pend = out_free;
        pend_last = 1'b1;
      end
      rtprb_pkg::S_RESULT: begin
        push_code_en = out_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtprb_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      free_r      <= '1;
      nw_r        <= rtprb_pkg::WINDOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        nw_r <= cfg_near_window;
      end
      if (push_code_en || push_pend) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        rtprb_pkg::S_INS_WA: begin
          free_r[slot_r] <= 1'b0;
        end
        rtprb_pkg::S_INS_WB: begin
          if (out_free) begin
            count_r <= count_r + CW'(1);
            unique case (mode_r)
              rtprb_pkg::INS_FIRST: begin
                head_r <= slot_r;
                tail_r <= slot_r;
              end
              rtprb_pkg::INS_HEAD: begin
                head_r <= slot_r;
              end
              rtprb_pkg::INS_TAIL: begin
                tail_r <= slot_r;
              end
              rtprb_pkg::INS_MID: begin
                tail_r <= tail_r;
              end
            endcase
          end
        end
        rtprb_pkg::S_DR_EVAL: begin
          if (out_free && (action_r == rtprb_pkg::ACT_DRAIN_REMOVE)) begin
            if (dr_take) begin
              free_r[cur_r] <= 1'b1;
            end else if (n_r != '0) begin
              head_r  <= cur_r;
              count_r <= count_r - CW'(n_r);
            end
          end
        end
        rtprb_pkg::S_DR_FLUSH: begin
          if (out_free && (action_r == rtprb_pkg::ACT_DRAIN_REMOVE)) begin
            if (int'(n_r) == int'(count_r)) begin
              head_r  <= '0;
              tail_r  <= '0;
              count_r <= '0;
            end else begin
              head_r  <= cur_r;
              count_r <= count_r - CW'(n_r);
            end
          end
        end
        default: begin
          count_r <= count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_code_en) begin
      out_status_r <= push_code;
      out_seq_r    <= '0;
      out_len_r    <= '0;
      out_first_r  <= '0;
      out_lseq_r   <= '0;
      out_tot_r    <= '0;
      out_last_r   <= 1'b1;
    end else if (push_pend) begin
      out_status_r <= rtprb_pkg::STAT_DRAINED;
      out_seq_r    <= pend_seq_r;
      out_len_r    <= pend_len_r;
      out_first_r  <= first_r;
      out_lseq_r   <= pend_seq_r;
      out_tot_r    <= pend_tot_r;
      out_last_r   <= pend_last;
    end
    unique case (state_r)
      rtprb_pkg::S_IDLE: begin
        if (in_take) begin
          action_r <= act_in;
          seq_r    <= in_seq_num & SEQ_MASK;
          len_r    <= in_payload_len;
          budget_r <= in_byte_budget;
          tg_r     <= in_take_gapped;
          f_r      <= tail_r;
          hf_r     <= 1'b1;
          hs_r     <= 1'b0;
          cur_r    <= head_r;
          n_r      <= '0;
          total_r  <= '0;
          slot_r   <= free_slot;
          mode_r   <= rtprb_pkg::INS_FIRST;
          unique case (act_in)
            rtprb_pkg::ACT_INSERT: begin
              status_r <= !in_packet_valid ? rtprb_pkg::STAT_INVALID : rtprb_pkg::STAT_FULL;
            end
            rtprb_pkg::ACT_DRAIN_KEEP, rtprb_pkg::ACT_DRAIN_REMOVE: begin
              status_r <= rtprb_pkg::STAT_EMPTY;
            end
            rtprb_pkg::ACT_RESERVED: begin
              status_r <= rtprb_pkg::STAT_INVALID;
            end
          endcase
        end
      end
      rtprb_pkg::S_INS_WALK: begin
        if (btw) begin
          status_r <= rtprb_pkg::STAT_NO_SLOT;
          slot_r   <= free_slot;
          priority if (!hf_r) begin
            mode_r <= rtprb_pkg::INS_HEAD;
          end else if (hs_r) begin
            mode_r <= rtprb_pkg::INS_MID;
          end else begin
            mode_r <= rtprb_pkg::INS_TAIL;
          end
        end else begin
          sc_r     <= f_r;
          sc_seq_r <= rd_seq;
          hs_r     <= hf_r;
          if (hf_r) begin
            if (f_r == head_r) begin
              hf_r <= 1'b0;
            end else begin
              f_r <= rd_prev;
            end
          end
        end
      end
      rtprb_pkg::S_DR_EVAL: begin
        if (out_free && dr_take) begin
          pend_seq_r <= rd_seq;
          pend_len_r <= rd_len;
          pend_tot_r <= total_add;
          total_r    <= total_add;
          n_r        <= n_inc;
          cur_r      <= rd_next;
          if (n_r == '0) begin
            first_r <= rd_seq;
          end
        end
      end
      default: begin
        n_r <= n_r;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_out_seq     = out_seq_r;
  assign out_out_len     = out_len_r;
  assign out_first_seq   = out_first_r;
  assign out_last_seq    = out_lseq_r;
  assign out_total_bytes = out_tot_r;
  assign out_last        = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("entry count above table depth");

  a_free_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtprb_pkg::S_IDLE) |-> ($countones(free_r) == DEPTH - int'(count_r)))
    else $error("free slots disagree with entry count");

  a_empty_all_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rtprb_pkg::S_IDLE) && (count_r == '0)) |-> (&free_r))
    else $error("empty table holds a used slot");

endmodule

// ----- dv/rtp_reorder_buffer_core_test.sv -----
// ----------------------------------------------------------------------------
// rtp_reorder_buffer_core_test
// Self-checking bench for the RTP reorder buffer: directed and random inserts
// and drains over several window settings, checked against a built-in
// predictor of the linked descriptor table, with random idling on both sides.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 32;

  typedef struct {
    rtprb_pkg::action_t          act;
    logic [rtprb_pkg::SEQ_W-1:0] seq;
    logic [rtprb_pkg::LEN_W-1:0] len;
    logic                        pv;
    logic [15:0]                 budget;
    logic                        tg;
  } pkt_req_t;

  typedef struct {
    rtprb_pkg::status_t          st;
    logic [rtprb_pkg::SEQ_W-1:0] seq;
    logic [rtprb_pkg::LEN_W-1:0] len;
    logic [rtprb_pkg::SEQ_W-1:0] first;
    logic [rtprb_pkg::SEQ_W-1:0] lst;
    logic [15:0]                 total;
    logic                        lt;
  } drain_rec_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_packet_valid, in_take_gapped;
  logic [rtprb_pkg::ACT_W-1:0] in_action;
  logic [rtprb_pkg::SEQ_W-1:0] in_seq_num;
  logic [rtprb_pkg::LEN_W-1:0] in_payload_len;
  logic [rtprb_pkg::BUDGET_W-1:0] in_byte_budget;
  logic out_valid, out_stall, out_last;
  logic [rtprb_pkg::STATUS_W-1:0] out_status;
  logic [rtprb_pkg::SEQ_W-1:0] out_out_seq, out_first_seq, out_last_seq;
  logic [rtprb_pkg::LEN_W-1:0] out_out_len;
  logic [rtprb_pkg::BUDGET_W-1:0] out_total_bytes;
  logic cfg_wr_en;
  logic [rtprb_pkg::WIN_W-1:0] cfg_near_window;

  rtp_reorder_buffer_core i_dut (.*);

  pkt_req_t   pending_q[$];
  drain_rec_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit transfer_seen = 0;
  bit hold_req = 0, hold_done = 0;
  int hold_cnt = 0;

  // table model
  logic [15:0] t_seq[TBL_DEPTH];
  logic [11:0] t_len[TBL_DEPTH];
  int t_next[TBL_DEPTH], t_prev[TBL_DEPTH];
  int t_head = 0, t_tail = 0, t_count = 0;
  logic [TBL_DEPTH-1:0] t_free = '1;
  logic [14:0] t_window = rtprb_pkg::WINDOW_RESET;

  function automatic longint wrap_dist(logic [15:0] a, logic [15:0] b);
    bit [31:0] m, aa, bb, dab, dba, mn, d1, d2, d3, d4;
    m = 32'd65535; aa = a; bb = b;
    dab = (aa - bb) & m; dba = (bb - aa) & m;
    mn = dab < dba ? dab : dba;
    if (mn <= t_window) begin
      d1 = aa - bb; d2 = bb + m + 1 - aa; d3 = bb - aa; d4 = aa + m + 1 - bb;
      if (d1 < d2 && d1 < d3 && d1 < d4) return -longint'(d1);
      if (d2 < d1 && d2 < d3 && d2 < d4) return longint'(d2);
      if (d3 < d1 && d3 < d2 && d3 < d4) return longint'(d3);
      return -longint'(d4);
    end
    d1 = aa - bb; d3 = bb - aa;
    return longint'(d1 < d3 ? d1 : d3);
  endfunction

  function automatic int grab_slot();
    int i;
    for (i = 0; i < TBL_DEPTH; i++) if (t_free[i]) break;
    if (i >= TBL_DEPTH) i = 0;
    t_free[i] = 1'b0;
    return i;
  endfunction

  function automatic rtprb_pkg::status_t place_packet(pkt_req_t r);
    bit hf, hs, btw;
    int f, sc, n;
    if (!r.pv) return rtprb_pkg::STAT_INVALID;
    if (t_count >= TBL_DEPTH) return rtprb_pkg::STAT_FULL;
    if (t_count == 0) begin
      n = grab_slot();
      t_seq[n] = r.seq; t_len[n] = r.len;
      t_head = n; t_tail = n; t_count = 1;
      return rtprb_pkg::STAT_INSERTED;
    end
    hf = 1; hs = 0; f = t_tail; sc = 0;
    for (int it = 0; it <= TBL_DEPTH + 1; it++) begin
      btw = 1;
      if (hf && hs) btw = wrap_dist(t_seq[f], r.seq) >= 0 && wrap_dist(r.seq, t_seq[sc]) >= 0;
      else if (hf) btw = wrap_dist(t_seq[f], r.seq) >= 0;
      else if (hs) btw = wrap_dist(r.seq, t_seq[sc]) <= 0;
      if (btw) break;
      sc = f; hs = hf;
      if (hf) begin
        if (f == t_head) hf = 0;
        else f = t_prev[f];
      end
    end
    if (!hf && !hs) return rtprb_pkg::STAT_NO_SLOT;
    n = grab_slot();
    t_seq[n] = r.seq; t_len[n] = r.len;
    if (!hf) begin
      t_next[n] = t_head; t_prev[t_head] = n; t_head = n;
    end else if (hs) begin
      t_next[f] = n; t_prev[sc] = n; t_prev[n] = f; t_next[n] = sc;
    end else begin
      t_next[f] = n; t_prev[n] = f; t_tail = n;
    end
    t_count++;
    return rtprb_pkg::STAT_INSERTED;
  endfunction

  function automatic void predict_transfer(pkt_req_t r);
    drain_rec_t e, outs[$];
    int cur, nx;
    logic [15:0] total, first;
    e = '{rtprb_pkg::STAT_INVALID, 0, 0, 0, 0, 0, 1'b1};
    if (r.act == rtprb_pkg::ACT_INSERT) begin
      e.st = place_packet(r);
      expected_q.push_back(e);
      return;
    end
    if (r.act == rtprb_pkg::ACT_RESERVED) begin
      expected_q.push_back(e);
      return;
    end
    if (t_count == 0) begin
      e.st = rtprb_pkg::STAT_EMPTY;
      expected_q.push_back(e);
      return;
    end
    cur = t_head; total = 0; first = 0;
    while (outs.size() < rtprb_pkg::MAX_RESULTS && outs.size() < t_count) begin
      if (32'(t_len[cur]) >= 32'(r.budget - total)) break;
      total += 16'(t_len[cur]);
      if (outs.size() == 0) first = t_seq[cur];
      outs.push_back('{rtprb_pkg::STAT_DRAINED, t_seq[cur], t_len[cur], first, t_seq[cur],
                       total, 1'b0});
      if (cur == t_tail) break;
      nx = t_next[cur];
      if (!r.tg && !(t_seq[cur] + 16'd1 == t_seq[nx])) break;
      cur = nx;
    end
    if (outs.size() > 0) outs[$].lt = 1'b1;
    if (r.act == rtprb_pkg::ACT_DRAIN_REMOVE) begin
      foreach (outs[k]) begin
        if (t_count == 0) break;
        t_free[t_head] = 1'b1;
        if (t_count == 1) begin
          t_count = 0; t_head = 0; t_tail = 0;
        end else begin
          t_head = t_next[t_head];
          t_count--;
        end
      end
    end
    foreach (outs[k]) expected_q.push_back(outs[k]);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (!(in_valid && !transfer_seen)) begin
      if (rst_n && pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pkt_req_t r;
        r = pending_q.pop_front();
        in_valid        <= 1'b1;
        in_action       <= r.act;
        in_seq_num      <= r.seq;
        in_payload_len  <= r.len;
        in_packet_valid <= r.pv;
        in_byte_budget  <= r.budget;
        in_take_gapped  <= r.tg;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    transfer_seen = 0;
    if (rst_n) begin
      if (cfg_wr_en) t_window = cfg_near_window;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status %0d seq %0d", $time, out_status, out_out_seq);
        end else begin
          drain_rec_t e;
          e = expected_q.pop_front();
          if (out_status !== e.st || out_out_seq !== e.seq || out_out_len !== e.len ||
              out_first_seq !== e.first || out_last_seq !== e.lst ||
              out_total_bytes !== e.total || out_last !== e.lt) begin
            errors++;
            $display("%0t: mismatch exp st=%0d seq=%0d len=%0d first=%0d last_seq=%0d",
                     $time, e.st, e.seq, e.len, e.first, e.lst);
            $display("%0t:          exp tot=%0d last=%0b", $time, e.total, e.lt);
            $display("%0t:          got st=%0d seq=%0d len=%0d first=%0d last_seq=%0d",
                     $time, out_status, out_out_seq, out_out_len, out_first_seq, out_last_seq);
            $display("%0t:          got tot=%0d last=%0b", $time, out_total_bytes, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pkt_req_t r;
        r = '{rtprb_pkg::action_t'(in_action), in_seq_num, in_payload_len, in_packet_valid,
              in_byte_budget, in_take_gapped};
        predict_transfer(r);
        transfer_seen = 1;
      end
    end
  end

  function automatic void add_pkt(rtprb_pkg::action_t a, int s, int l, bit pv, int b, bit tg);
    pending_q.push_back('{a, 16'(s), 12'(l), pv, 16'(b), tg});
  endfunction

  function automatic int add_random(int base);
    int k, n;
    n = 0;
    case ($urandom_range(9))
      0: begin
        for (int i = 0; i < 34; i++) begin
          add_pkt(rtprb_pkg::ACT_INSERT, base + i, $urandom_range(4095), 1, 0, 0);
        end
        add_pkt(rtprb_pkg::ACT_DRAIN_REMOVE, 0, 0, 0, 65535, $urandom_range(1));
        add_pkt(rtprb_pkg::ACT_DRAIN_REMOVE, 0, 0, 0, 65535, 1);
        n = 36;
      end
      1, 2: begin
        add_pkt(rtprb_pkg::action_t'($urandom_range(2)), $urandom, $urandom, $urandom,
                $urandom, $urandom);
        n = 1;
      end
      default: begin
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++)
          add_pkt(rtprb_pkg::ACT_INSERT, base + $urandom_range(k + 2), $urandom_range(1500),
                  $urandom_range(15) != 0, $urandom, $urandom);
        add_pkt($urandom_range(3) == 0 ? rtprb_pkg::ACT_DRAIN_KEEP : rtprb_pkg::ACT_DRAIN_REMOVE,
                $urandom, $urandom, $urandom,
                $urandom_range(3) == 0 ? $urandom : $urandom_range(4000, 65535),
                $urandom_range(1));
        n = k + 1;
      end
    endcase
    return n;
  endfunction

  task automatic settle();
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_window(logic [rtprb_pkg::WIN_W-1:0] w);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_near_window <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int base, cnt;
    logic [rtprb_pkg::WIN_W-1:0] windows[6];
    in_valid = 0; in_action = 0; in_seq_num = 0; in_payload_len = 0;
    in_packet_valid = 0; in_byte_budget = 0; in_take_gapped = 0;
    out_stall = 0; cfg_wr_en = 0; cfg_near_window = 0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    windows = '{rtprb_pkg::WINDOW_RESET, 15'd0, 15'd32767, 15'd5, 15'($urandom),
                rtprb_pkg::WINDOW_RESET};
    base = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = ph < 2 ? 23 : (ph < 4 ? 67 : 0);
      recv_idle_pct = ph < 2 ? 67 : (ph < 4 ? 23 : 0);
      write_window(windows[ph]);
      if (ph == 0) begin
        add_pkt(rtprb_pkg::ACT_DRAIN_KEEP, 0, 0, 1, 65535, 1);
        add_pkt(rtprb_pkg::ACT_DRAIN_REMOVE, 0, 0, 1, 65535, 0);
        add_pkt(rtprb_pkg::ACT_INSERT, 100, 50, 0, 0, 0);
        add_pkt(rtprb_pkg::ACT_INSERT, 65535, 4095, 1, 0, 0);
        add_pkt(rtprb_pkg::ACT_INSERT, 0, 0, 1, 65535, 1);
        add_pkt(rtprb_pkg::ACT_INSERT, 65534, 10, 1, 0, 0);
        add_pkt(rtprb_pkg::ACT_INSERT, 0, 7, 1, 0, 0);
        add_pkt(rtprb_pkg::ACT_INSERT, 2, 20, 1, 0, 0);
        add_pkt(rtprb_pkg::ACT_INSERT, 32768, 30, 1, 0, 0);
        add_pkt(rtprb_pkg::ACT_DRAIN_KEEP, 0, 0, 1, 0, 0);
        add_pkt(rtprb_pkg::ACT_DRAIN_KEEP, 0, 0, 1, 10, 0);
        add_pkt(rtprb_pkg::ACT_DRAIN_KEEP, 0, 0, 1, 11, 0);
        add_pkt(rtprb_pkg::ACT_DRAIN_KEEP, 0, 0, 1, 65535, 0);
        add_pkt(rtprb_pkg::ACT_DRAIN_KEEP, 0, 0, 1, 65535, 1);
        add_pkt(rtprb_pkg::ACT_DRAIN_REMOVE, 0, 0, 1, 5000, 0);
        add_pkt(rtprb_pkg::ACT_DRAIN_REMOVE, 0, 0, 1, 65535, 1);
        add_pkt(rtprb_pkg::ACT_DRAIN_REMOVE, 0, 0, 1, 65535, 1);
      end
      if (ph == 4) hold_req = 1;
      cnt = 0;
      while (cnt < 80) begin
        cnt += add_random(base);
        base += $urandom_range(1, 10);
      end
      settle();
    end
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
